/* hdl/iu2x_pkg.sv */
// ----------------------------------------------------------------------------
// iu2x_pkg
// Shared types and constants of the 2x image upscaler.
// ----------------------------------------------------------------------------
package iu2x_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // One classified source pixel: the pixels and line-buffer values around it,
  // the doubled coordinates and the columns and rows it finishes.
  typedef struct packed {
    logic [PIX_W-1:0]   cur_l;
    logic [PIX_W-1:0]   cur_r;
    logic [PIX_W-1:0]   top_l;
    logic [PIX_W-1:0]   top_r;
    logic [COORD_W-1:0] row0;
    logic [COORD_W-1:0] col0;
    logic               has_left;
    logic               has_top;
    logic               last_col;
    logic               last_row;
  } entry_t;

  typedef enum logic [1:0] {
    ROW_ABOVE,
    ROW_MID,
    ROW_BELOW
  } row_pos_t;

endpackage

/* hdl/image_upscale_2x_interpolate_top.sv */
// ----------------------------------------------------------------------------
// image_upscale_2x_interpolate_top
// Streaming 2x image upscaler with linear fill between source pixels.
//
// Source pixels enter on in_valid/in_ready in raster order; output pixels
// leave on out_valid/out_ready with their doubled row and column, run_last
// on the last word caused by a source pixel and frame_done on the last word
// of the image. Each source pixel yields none to twelve output words, four
// on average, and words leave at one per cycle while out_ready allows; the
// output register's one word per cycle sets that rate.
// A pixel's first word passes the entry register, queue and output register.
// A four-entry queue parts the front end (counters, line buffer) from the
// output sequencer, so pixels are still taken while the receiver stalls
// until the queue fills.
// cfg_valid/cfg_ready write source_width (index 0) or source_height
// (index 1), taken at once, and restart the frame; write only when idle.
// Reset sets both sizes to 1 and clears position and control state; the
// line buffer keeps no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module image_upscale_2x_interpolate_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iu2x_pkg::PIX_W-1:0]     pixel_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iu2x_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iu2x_pkg::CFG_W-1:0]     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [iu2x_pkg::COORD_W-1:0]   out_row,
  output logic [iu2x_pkg::COORD_W-1:0]   out_col,
  output logic [iu2x_pkg::PIX_W-1:0]     out_value,
  output logic                           run_last,
  output logic                           frame_done
);
  import iu2x_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  iu2x_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  iu2x_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  iu2x_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

endmodule

/* hdl/iu2x_front.sv */
// ----------------------------------------------------------------------------
// iu2x_front
// Accepts source pixels, tracks row and column, keeps the line buffer and
// classifies each pixel past column 0 or ending a row into one back-end entry.
// ----------------------------------------------------------------------------
module iu2x_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iu2x_pkg::PIX_W-1:0]     pixel_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iu2x_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iu2x_pkg::CFG_W-1:0]     cfg_data,
  output logic                           push_valid,
  input  logic                           push_ready,
  output iu2x_pkg::entry_t               push_entry
);
  import iu2x_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]    width_eff;
  logic [HW-1:0]    height_eff;
  logic [CW-1:0]    col_count;
  logic [RW-1:0]    row_count;
  logic [PIX_W-1:0] prev_pixel;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line_rd;
  logic [PIX_W-1:0] prev_top;

  logic             b_valid;
  logic [PIX_W-1:0] b_cur_l;
  logic [PIX_W-1:0] b_cur_r;
  logic [COORD_W-1:0] b_row0;
  logic [COORD_W-1:0] b_col0;
  logic             b_has_left;
  logic             b_has_top;
  logic             b_last_col;
  logic             b_last_row;

  logic          accept;
  logic          b_need;
  logic          b_adv;
  logic [WW:0]   col_inc;
  logic [HW:0]   row_inc;
  logic          a_last_col;
  logic          a_last_row;

  assign cfg_ready  = 1'b1;
  assign col_inc    = (WW+1)'(col_count) + 1'b1;
  assign row_inc    = (HW+1)'(row_count) + 1'b1;
  assign a_last_col = col_inc >= {1'b0, width_eff};
  assign a_last_row = row_inc >= {1'b0, height_eff};

  assign b_need     = b_has_left || b_last_col;
  assign b_adv      = !b_valid || !b_need || push_ready;
  assign in_ready   = b_adv;
  assign accept     = in_valid && in_ready;
  assign push_valid = b_valid && b_need;

  always_comb begin
    push_entry.cur_l    = b_cur_l;
    push_entry.cur_r    = b_cur_r;
    push_entry.top_l    = prev_top;
    push_entry.top_r    = line_rd;
    push_entry.row0     = b_row0;
    push_entry.col0     = b_col0;
    push_entry.has_left = b_has_left;
    push_entry.has_top  = b_has_top;
    push_entry.last_col = b_last_col;
    push_entry.last_row = b_last_row;
  end

  // read old entry, then overwrite it with the current row's pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd              <= line_mem[col_count];
      line_mem[col_count]  <= pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_adv) begin
      prev_top <= line_rd;
    end
    if (accept) begin
      b_cur_l    <= prev_pixel;
      b_cur_r    <= pixel_value;
      b_row0     <= COORD_W'({row_count, 1'b0});
      b_col0     <= COORD_W'({col_count, 1'b0});
      b_has_left <= col_count != '0;
      b_has_top  <= row_count != '0;
      b_last_col <= a_last_col;
      b_last_row <= a_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(1);
      height_eff <= HW'(1);
      col_count  <= '0;
      row_count  <= '0;
      prev_pixel <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH: begin
          if (cfg_data == '0) begin
            width_eff <= WW'(1);
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            width_eff <= WW'(MAX_WIDTH);
          end else begin
            width_eff <= WW'(cfg_data);
          end
          col_count  <= '0;
          row_count  <= '0;
          prev_pixel <= '0;
        end
        REG_HEIGHT: begin
          if (cfg_data == '0) begin
            height_eff <= HW'(1);
          end else if (32'(cfg_data) > MAX_HEIGHT) begin
            height_eff <= HW'(MAX_HEIGHT);
          end else begin
            height_eff <= HW'(cfg_data);
          end
          col_count  <= '0;
          row_count  <= '0;
          prev_pixel <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      prev_pixel <= pixel_value;
      if (a_last_col) begin
        col_count <= '0;
        row_count <= a_last_row ? '0 : RW'(row_inc);
      end else begin
        col_count <= CW'(col_inc);
      end
    end
  end

endmodule

/* hdl/iu2x_queue.sv */
// ----------------------------------------------------------------------------
// iu2x_queue
// Four-entry queue of work entries between the front and back ends.
// ----------------------------------------------------------------------------
module iu2x_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  iu2x_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output iu2x_pkg::entry_t pop_entry
);
  import iu2x_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != (PW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/iu2x_back.sv */
// ----------------------------------------------------------------------------
// iu2x_back
// Walks each work entry through its output pixels, one word a cycle while
// out_ready allows, and holds the result in an output register.
// ----------------------------------------------------------------------------
module iu2x_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  iu2x_pkg::entry_t             pop_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iu2x_pkg::COORD_W-1:0] out_row,
  output logic [iu2x_pkg::COORD_W-1:0] out_col,
  output logic [iu2x_pkg::PIX_W-1:0]   out_value,
  output logic                         run_last,
  output logic                         frame_done
);
  import iu2x_pkg::*;

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W:1];
  endfunction

  logic     fresh;
  logic     pos_col;
  row_pos_t pos_row;
  logic     pos_sub;

  logic     cur_col;
  row_pos_t cur_row;
  logic     cur_sub;
  logic     nxt_col;
  row_pos_t nxt_row;
  logic     nxt_sub;
  logic     is_last;
  logic     load;
  row_pos_t start_row;

  logic [PIX_W-1:0]   cl;
  logic [PIX_W-1:0]   cr;
  logic [PIX_W-1:0]   tl;
  logic [PIX_W-1:0]   tr;
  logic [PIX_W-1:0]   cur_h;
  logic [PIX_W-1:0]   top_h;
  logic [PIX_W-1:0]   val;
  logic [COORD_W-1:0] row_v;
  logic [COORD_W-1:0] col_v;

  assign load      = pop_valid && (!out_valid || out_ready);
  assign pop_ready = load && is_last;
  assign start_row = pop_entry.has_top ? ROW_ABOVE : ROW_MID;

  always_comb begin
    if (fresh) begin
      cur_col = !pop_entry.has_left;
      cur_row = start_row;
      cur_sub = 1'b0;
    end else begin
      cur_col = pos_col;
      cur_row = pos_row;
      cur_sub = pos_sub;
    end

    nxt_col = cur_col;
    nxt_row = cur_row;
    nxt_sub = 1'b0;
    is_last = 1'b0;
    if (!cur_sub) begin
      nxt_sub = 1'b1;
    end else begin
      case (cur_row)
        ROW_ABOVE: nxt_row = ROW_MID;
        ROW_MID: begin
          if (pop_entry.last_row) begin
            nxt_row = ROW_BELOW;
          end else if (!cur_col && pop_entry.last_col) begin
            nxt_col = 1'b1;
            nxt_row = start_row;
          end else begin
            is_last = 1'b1;
          end
        end
        default: begin
          if (!cur_col && pop_entry.last_col) begin
            nxt_col = 1'b1;
            nxt_row = start_row;
          end else begin
            is_last = 1'b1;
          end
        end
      endcase
    end

    if (cur_col) begin
      cl    = pop_entry.cur_r;
      cr    = pop_entry.cur_r;
      tl    = pop_entry.top_r;
      tr    = pop_entry.top_r;
      cur_h = pop_entry.cur_r;
      top_h = pop_entry.top_r;
      col_v = pop_entry.col0 + COORD_W'(cur_sub);
    end else begin
      cl    = pop_entry.cur_l;
      cr    = pop_entry.cur_r;
      tl    = pop_entry.top_l;
      tr    = pop_entry.top_r;
      cur_h = avg2(cl, cr);
      top_h = avg2(tl, tr);
      col_v = pop_entry.col0 - COORD_W'(2) + COORD_W'(cur_sub);
    end

    case (cur_row)
      ROW_ABOVE: begin
        row_v = pop_entry.row0 - COORD_W'(1);
        val   = cur_sub ? avg2(top_h, cur_h) : avg2(tl, cl);
      end
      ROW_MID: begin
        row_v = pop_entry.row0;
        val   = cur_sub ? cur_h : cl;
      end
      default: begin
        row_v = pop_entry.row0 + COORD_W'(1);
        val   = cur_sub ? cur_h : cl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh   <= 1'b1;
      pos_col <= 1'b0;
      pos_row <= ROW_MID;
      pos_sub <= 1'b0;
    end else if (load) begin
      fresh   <= is_last;
      pos_col <= nxt_col;
      pos_row <= nxt_row;
      pos_sub <= nxt_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row    <= row_v;
      out_col    <= col_v;
      out_value  <= val;
      run_last   <= is_last;
      frame_done <= is_last && pop_entry.last_col && pop_entry.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
